/* rtl/core/flash_wear_leveling_map_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the flash wear-leveling map checker.
// Each macro expands to one labeled concurrent assertion on clk_i that is
// switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FLASH_WEAR_LEVELING_MAP_MACROS_SVH
`define FLASH_WEAR_LEVELING_MAP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FWLM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fwlm_pkg.sv */
// ----------------------------------------------------------------------------
// fwlm_pkg
// Shared types and constants of the flash wear-leveling map.
// ----------------------------------------------------------------------------
package fwlm_pkg;

  localparam int unsigned NumBlocksDef = 32;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned NumLogical   = 32;
  localparam int unsigned LbW          = 5;
  localparam int unsigned FieldW       = 5;
  localparam int unsigned ThrW         = 16;
  localparam int unsigned PaddrW       = 3;
  localparam int unsigned PdataW       = 32;

  localparam logic [ThrW-1:0] ThrReset = 16'd5;

  // Word index of the wear threshold register.
  localparam logic RegWearThreshold = 1'b0;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_NOP   = 2'd3
  } command_e;

  typedef enum logic [2:0] {
    ACT_READ     = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_COPY     = 3'd2,
    ACT_ERASE    = 3'd3,
    ACT_UNMAPPED = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ERASE_RD,
    ST_ERASE_WR,
    ST_SCAN,
    ST_ALLOC,
    ST_MIG_COPY,
    ST_MIG_ERASE,
    ST_REMAP,
    ST_FINAL
  } state_e;

  // Control from the sequencer to a least-erased tracker.
  typedef struct packed {
    logic clr;
    logic en;
  } trk_ctrl_t;

endpackage

/* rtl/core/fwlm_least.sv */
// ----------------------------------------------------------------------------
// fwlm_least
// Running minimum of erase counts over a sequential scan; the first index
// wins on ties.
// ----------------------------------------------------------------------------
module fwlm_least
  import fwlm_pkg::*;
#(
  parameter int unsigned PW         = 5,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trk_ctrl_t             ctrl_i,
  input  logic [PW-1:0]         idx_i,
  input  logic [COUNT_BITS-1:0] cnt_i,
  output logic                  found_o,
  output logic [PW-1:0]         idx_o,
  output logic [COUNT_BITS-1:0] cnt_o
);

  logic                  found_q;
  logic [PW-1:0]         idx_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  take;

  // Strictly smaller only, so an earlier index keeps a tie.
  assign take = ctrl_i.en && (!found_q || (cnt_i < cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctrl_i.clr) begin
      idx_q <= idx_i;
      cnt_q <= cnt_i;
    end
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign cnt_o   = cnt_q;

endmodule

/* rtl/core/flash_wear_leveling_map.sv */
// ----------------------------------------------------------------------------
// flash_wear_leveling_map
// Logical-to-physical flash block map with erase counting and wear leveling.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                       Payload
//  --------  ------------------------------  ---------------------------------
//  request   start / busy                    command_i, logical_block_i
//  result    result_valid_o (one cycle)      action_o, phys_block_o,
//                                            source_block_o, last_o
//  config    APB psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  A write scans the erase-count memory, one entry per cycle, after first
//  erasing the block it replaces, if it had one; when a cold block migrates,
//  the map memory is also scanned for the logical block that maps to it.
//  After reset the block clears the erase-count memory with busy high;
//  configuration writes are taken during that time.
//  Results cannot be stalled: each one is shown for exactly one cycle.
//
// The state lives in two synchronous memories with registered read data:
// the map memory (32 physical indexes) and the block memory (an in-use bit
// and an erase count per physical block). Map entries carry valid bits in
// flip-flops. A sequencer reads, modifies and writes these memories one
// access at a time, so an access never overlaps another one to the same entry.
module flash_wear_leveling_map
  import fwlm_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NumBlocksDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel.
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command_i,
  input  logic [LbW-1:0]      logical_block_i,
  // Result channel.
  output logic                result_valid_o,
  output logic [2:0]          action_o,
  output logic [FieldW-1:0]   phys_block_o,
  output logic [FieldW-1:0]   source_block_o,
  output logic                last_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [PdataW-1:0]   pwdata,
  output logic [PdataW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned PW = $clog2(NUM_BLOCKS);
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned KW = $clog2(NumLogical + 1);
  localparam int unsigned TW = (COUNT_BITS > ThrW) ? COUNT_BITS : ThrW;
  localparam int unsigned MW = COUNT_BITS + 1;

  // --------------------------------------------------------------------------
  // Configuration register.
  // --------------------------------------------------------------------------
  logic [ThrW-1:0] thr_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr && (paddr[2] == RegWearThreshold)) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegWearThreshold) ? {{(PdataW-ThrW){1'b0}}, thr_q} : '0;

  // --------------------------------------------------------------------------
  // Memories.
  // --------------------------------------------------------------------------
  logic [PW-1:0]  map_mem [NumLogical];
  logic           map_re;
  logic [LbW-1:0] map_raddr;
  logic [PW-1:0]  map_rdata_q;
  logic           map_we;
  logic [LbW-1:0] map_waddr;
  logic [PW-1:0]  map_wdata;

  logic [MW-1:0]  blk_mem [NUM_BLOCKS];
  logic           blk_re;
  logic [PW-1:0]  blk_raddr;
  logic [MW-1:0]  blk_rdata_q;
  logic           blk_we;
  logic [PW-1:0]  blk_waddr;
  logic [MW-1:0]  blk_wdata;

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata_q <= map_mem[map_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    if (blk_re) begin
      blk_rdata_q <= blk_mem[blk_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer registers.
  // --------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [NumLogical-1:0] valid_q, valid_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [KW-1:0]         k_q, k_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [PW-1:0]         pidx_q, pidx_d;
  logic [LbW-1:0]        pk_q, pk_d;
  command_e              cmd_q;
  logic [LbW-1:0]        lb_q;
  logic [PW-1:0]         era_q, era_d;
  logic [PW-1:0]         p_q, p_d;
  logic [COUNT_BITS-1:0] pcnt_q, pcnt_d;
  logic                  accept;

  // Emission of one result.
  logic                  emit;
  action_e               e_act;
  logic [PW-1:0]         e_phys;
  logic [PW-1:0]         e_src;
  logic                  e_last;
  logic [PW+FieldW-1:0]  e_phys_ext;
  logic [PW+FieldW-1:0]  e_src_ext;

  logic                  res_vld_q;
  action_e               act_q;
  logic [FieldW-1:0]     phys_q;
  logic [FieldW-1:0]     src_q;
  logic                  last_q;

  // Least-erased trackers for free and in-use blocks.
  trk_ctrl_t             free_ctrl, used_ctrl;
  logic                  free_found, used_found;
  logic [PW-1:0]         free_idx, used_idx;
  logic [COUNT_BITS-1:0] free_cnt, used_cnt;
  logic                  scan_clr;

  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_used;
  logic [COUNT_BITS-1:0] rd_cnt_inc;
  logic [COUNT_BITS-1:0] used_cnt_inc;
  logic                  mapped;
  logic                  below_thr;

  assign accept       = start && !busy;
  assign busy         = (state_q != ST_IDLE);
  assign rd_cnt       = blk_rdata_q[COUNT_BITS-1:0];
  assign rd_used      = blk_rdata_q[COUNT_BITS];
  assign rd_cnt_inc   = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign used_cnt_inc = (used_cnt == '1) ? used_cnt : used_cnt + COUNT_BITS'(1);
  assign mapped       = valid_q[lb_q];
  assign below_thr    = TW'(free_cnt) < TW'(thr_q);

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    idx_d      = idx_q;
    k_d        = k_q;
    rd_vld_d   = 1'b0;
    pidx_d     = pidx_q;
    pk_d       = pk_q;
    era_d      = era_q;
    p_d        = p_q;
    pcnt_d     = pcnt_q;
    map_re     = 1'b0;
    map_raddr  = logical_block_i;
    map_we     = 1'b0;
    map_waddr  = lb_q;
    map_wdata  = p_q;
    blk_re     = 1'b0;
    blk_raddr  = era_q;
    blk_we     = 1'b0;
    blk_waddr  = p_q;
    blk_wdata  = {1'b1, pcnt_q};
    emit       = 1'b0;
    e_act      = ACT_UNMAPPED;
    e_phys     = '0;
    e_src      = '0;
    e_last     = 1'b0;
    free_ctrl  = '0;
    used_ctrl  = '0;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the block memory to zero counts and free blocks.
        blk_we    = 1'b1;
        blk_waddr = idx_q[PW-1:0];
        blk_wdata = '0;
        if (idx_q == CW'(NUM_BLOCKS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          map_re    = 1'b1;
          map_raddr = logical_block_i;
          state_d   = ST_DECODE;
        end
      end

      ST_DECODE: begin
        era_d = map_rdata_q;
        unique case (cmd_q)
          CMD_READ: begin
            emit    = 1'b1;
            e_last  = 1'b1;
            e_act   = mapped ? ACT_READ : ACT_UNMAPPED;
            e_phys  = mapped ? map_rdata_q : '0;
            state_d = ST_IDLE;
          end
          CMD_WRITE: begin
            if (mapped) begin
              valid_d[lb_q] = 1'b0;
              state_d       = ST_ERASE_RD;
            end else begin
              idx_d   = '0;
              state_d = ST_SCAN;
            end
          end
          CMD_ERASE: begin
            if (mapped) begin
              valid_d[lb_q] = 1'b0;
              state_d       = ST_ERASE_RD;
            end else begin
              emit    = 1'b1;
              e_last  = 1'b1;
              state_d = ST_IDLE;
            end
          end
          default: begin
            emit    = 1'b1;
            e_last  = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_ERASE_RD: begin
        blk_re    = 1'b1;
        blk_raddr = era_q;
        state_d   = ST_ERASE_WR;
      end

      ST_ERASE_WR: begin
        blk_we    = 1'b1;
        blk_waddr = era_q;
        blk_wdata = {1'b0, rd_cnt_inc};
        emit      = 1'b1;
        e_act     = ACT_ERASE;
        e_phys    = era_q;
        if (cmd_q == CMD_ERASE) begin
          e_last  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; the data of the previous read is scored.
        free_ctrl.en = rd_vld_q && !rd_used;
        used_ctrl.en = rd_vld_q && rd_used;
        if (idx_q < CW'(NUM_BLOCKS)) begin
          blk_re    = 1'b1;
          blk_raddr = idx_q[PW-1:0];
          pidx_d    = idx_q[PW-1:0];
          rd_vld_d  = 1'b1;
          idx_d     = idx_q + CW'(1);
        end else begin
          state_d = ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        if (!free_found) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = ST_IDLE;
        end else if (used_found && !below_thr) begin
          p_d     = used_idx;
          pcnt_d  = used_cnt_inc;
          state_d = ST_MIG_COPY;
        end else begin
          p_d     = free_idx;
          pcnt_d  = free_cnt;
          state_d = ST_FINAL;
        end
      end

      ST_MIG_COPY: begin
        // The worn free block takes over the cold block's data.
        blk_we    = 1'b1;
        blk_waddr = free_idx;
        blk_wdata = {1'b1, free_cnt};
        emit      = 1'b1;
        e_act     = ACT_COPY;
        e_phys    = free_idx;
        e_src     = p_q;
        state_d   = ST_MIG_ERASE;
      end

      ST_MIG_ERASE: begin
        // The cold block is rewritten at ST_FINAL with its raised count.
        emit    = 1'b1;
        e_act   = ACT_ERASE;
        e_phys  = p_q;
        k_d     = '0;
        state_d = ST_REMAP;
      end

      ST_REMAP: begin
        // Find the first logical block mapped to the cold block.
        if (rd_vld_q && valid_q[pk_q] && (map_rdata_q == p_q)) begin
          map_we    = 1'b1;
          map_waddr = pk_q;
          map_wdata = free_idx;
          state_d   = ST_FINAL;
        end else if (k_q < KW'(NumLogical)) begin
          map_re    = 1'b1;
          map_raddr = k_q[LbW-1:0];
          pk_d      = k_q[LbW-1:0];
          rd_vld_d  = 1'b1;
          k_d       = k_q + KW'(1);
        end else begin
          state_d = ST_FINAL;
        end
      end

      ST_FINAL: begin
        map_we        = 1'b1;
        map_waddr     = lb_q;
        map_wdata     = p_q;
        valid_d[lb_q] = 1'b1;
        blk_we        = 1'b1;
        blk_waddr     = p_q;
        blk_wdata     = {1'b1, pcnt_q};
        emit          = 1'b1;
        e_act         = ACT_WRITE;
        e_phys        = p_q;
        e_last        = 1'b1;
        state_d       = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Trackers restart whenever a scan is entered.
    scan_clr      = (state_d == ST_SCAN) && (state_q != ST_SCAN);
    free_ctrl.clr = scan_clr;
    used_ctrl.clr = scan_clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      valid_q   <= '0;
      idx_q     <= '0;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      k_q       <= k_d;
      rd_vld_q  <= rd_vld_d;
      res_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    pk_q   <= pk_d;
    era_q  <= era_d;
    p_q    <= p_d;
    pcnt_q <= pcnt_d;
    if (accept) begin
      cmd_q <= command_e'(command_i);
      lb_q  <= logical_block_i;
    end
  end

  // Result register; physical indexes show their low five bits.
  assign e_phys_ext = {{FieldW{1'b0}}, e_phys};
  assign e_src_ext  = {{FieldW{1'b0}}, e_src};

  always_ff @(posedge clk_i) begin
    if (emit) begin
      act_q  <= e_act;
      phys_q <= e_phys_ext[FieldW-1:0];
      src_q  <= e_src_ext[FieldW-1:0];
      last_q <= e_last;
    end
  end

  assign result_valid_o = res_vld_q;
  assign action_o       = act_q;
  assign phys_block_o   = phys_q;
  assign source_block_o = src_q;
  assign last_o         = last_q;

  // --------------------------------------------------------------------------
  // Least-erased trackers.
  // --------------------------------------------------------------------------
  fwlm_least #(
    .PW        (PW),
    .COUNT_BITS(COUNT_BITS)
  ) u_free (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (free_ctrl),
    .idx_i  (pidx_q),
    .cnt_i  (rd_cnt),
    .found_o(free_found),
    .idx_o  (free_idx),
    .cnt_o  (free_cnt)
  );

  fwlm_least #(
    .PW        (PW),
    .COUNT_BITS(COUNT_BITS)
  ) u_used (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (used_ctrl),
    .idx_i  (pidx_q),
    .cnt_i  (rd_cnt),
    .found_o(used_found),
    .idx_o  (used_idx),
    .cnt_o  (used_cnt)
  );

endmodule

/* rtl/core/fwlm_checker.sv */
// ----------------------------------------------------------------------------
// fwlm_checker
// Port-level checks of the flash wear-leveling map, bound to the top level.
// ----------------------------------------------------------------------------
`include "flash_wear_leveling_map_macros.svh"

module fwlm_checker
  import fwlm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input logic [2:0]        action_o,
  input logic [FieldW-1:0] phys_block_o,
  input logic [FieldW-1:0] source_block_o,
  input logic              last_o
);

  // An accepted request keeps the block busy in the next cycle.
  `FWLM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request transfer did not raise busy")

  // Every result comes from work that was under way in the previous cycle.
  `FWLM_ASSERT_SAME(a_result_from_work, result_valid_o, $past(busy), "result without a request")

  // The final result of a request leaves the block ready for the next one.
  `FWLM_ASSERT_SAME(a_last_frees, result_valid_o && last_o, !busy, "busy after final result")

  // Only a copy names a source block; an unmapped result names no block.
  `FWLM_ASSERT_SAME(a_src_zero, result_valid_o && (action_o != ACT_COPY),
                    source_block_o == '0, "source block set on a non-copy result")
  `FWLM_ASSERT_SAME(a_unmapped_zero, result_valid_o && (action_o == ACT_UNMAPPED),
                    phys_block_o == '0, "physical block set on an unmapped result")

endmodule

bind flash_wear_leveling_map fwlm_checker u_fwlm_checker (.*);
